// ----- rtl/core/fgd_pkg.sv -----
// Shared types, constants and tables of the f-k deghosting operator.
// No dependencies; every other file of the block imports this package.
package fgd_pkg;

  // Number of CORDIC rotations, capped at the size of the arctangent table.
  localparam int TRIG_ITERATIONS = 24;
  localparam int CORDIC_N = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;

  // Chain lengths: one root bit per square-root cell, one quotient bit per divider cell.
  localparam int SQRT_N = 31;
  localparam int DIV_N = 37;

  // Datapath widths of the CORDIC and of the divisor.
  localparam int CW = 34;
  localparam int DQW = 32;

  // Register reset values.
  localparam logic [31:0] SLOWNESS_RST = 32'd2863311;
  localparam logic [31:0] DEPTH_RST = 32'd655360;
  localparam logic [31:0] STAB_RST = 32'd167772;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_SLOWNESS = 2'd0;
  localparam logic [1:0] CFG_DEPTH = 2'd1;
  localparam logic [1:0] CFG_STAB = 2'd2;

  // 1/(2*pi) in Q0.64, CORDIC gain in Q2.30 and the fold limits in turns.
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sh40000000;
  localparam logic signed [CW-1:0] HALF_TURN = 34'sh80000000;

  // Sideband that travels with each request through every stage.
  typedef struct packed {
    logic               vld;
    logic               evan;
    logic               zdiv;
    logic               flip;
    logic [5:0]         sh;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
  } side_t;

  // Arctangent of 2^-idx in Q0.32 turns.
  function automatic logic signed [CW-1:0] atan_turns(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'h20000000;
      5'd1: v = 30'h12E4051E;
      5'd2: v = 30'h09FB385B;
      5'd3: v = 30'h051111D4;
      5'd4: v = 30'h028B0D43;
      5'd5: v = 30'h0145D7E1;
      5'd6: v = 30'h00A2F61E;
      5'd7: v = 30'h00517C55;
      5'd8: v = 30'h0028BE53;
      5'd9: v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return $signed({4'b0000, v});
  endfunction

endpackage

// ----- rtl/core/fgd_sqrt_cell.sv -----
// One cell of the square-root chain: consumes two radicand bits, yields one root bit.
// Depends on fgd_pkg for the sideband type.
module fgd_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  fgd_pkg::side_t side_i,
  input  logic [61:0]   op_i,
  input  logic [31:0]   rem_i,
  input  logic [30:0]   root_i,
  output fgd_pkg::side_t side_o,
  output logic [61:0]   op_o,
  output logic [31:0]   rem_o,
  output logic [30:0]   root_o
);
  import fgd_pkg::*;

  logic [33:0] cand;
  logic [33:0] trial;
  logic        take;
  side_t       side_q;
  logic [61:0] op_q;
  logic [31:0] rem_q;
  logic [30:0] root_q;

  // Trial subtraction of (4*root + 1) from the shifted remainder.
  assign cand = {rem_i, op_i[61:60]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take = (cand >= trial);

  // Sideband carries the valid bit and is cleared on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  // Data registers hand the partial result to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= {op_i[59:0], 2'b00};
      rem_q <= take ? 32'(cand - trial) : cand[31:0];
      root_q <= {root_i[29:0], take};
    end
  end

  assign side_o = side_q;
  assign op_o = op_q;
  assign rem_o = rem_q;
  assign root_o = root_q;

endmodule

// ----- rtl/core/fgd_cordic_cell.sv -----
// One CORDIC rotation cell in rotation mode, angles in fractions of a turn.
// Depends on fgd_pkg for widths, the sideband type and the arctangent table.
module fgd_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [4:0]                  idx_i,
  input  fgd_pkg::side_t              side_i,
  input  logic signed [fgd_pkg::CW-1:0] x_i,
  input  logic signed [fgd_pkg::CW-1:0] y_i,
  input  logic signed [fgd_pkg::CW-1:0] z_i,
  output fgd_pkg::side_t              side_o,
  output logic signed [fgd_pkg::CW-1:0] x_o,
  output logic signed [fgd_pkg::CW-1:0] y_o,
  output logic signed [fgd_pkg::CW-1:0] z_o
);
  import fgd_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;
  logic signed [CW-1:0] x_d;
  logic signed [CW-1:0] y_d;
  logic signed [CW-1:0] z_d;
  logic signed [CW-1:0] x_q;
  logic signed [CW-1:0] y_q;
  logic signed [CW-1:0] z_q;
  side_t                side_q;

  assign xs = x_i >>> idx_i;
  assign ys = y_i >>> idx_i;
  assign at = atan_turns(idx_i);

  // Rotate toward zero residual angle.
  always_comb begin
    if (!z_i[CW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign side_o = side_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- rtl/core/fgd_div_cell.sv -----
// One restoring-division cell: one quotient bit for each of the four output lanes.
// Depends on fgd_pkg for the divisor width and the sideband type.
module fgd_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  fgd_pkg::side_t               side_i,
  input  logic [fgd_pkg::DQW-1:0]      dq_i,
  input  logic [3:0]                   neg_i,
  input  logic [3:0][fgd_pkg::DQW-1:0] rem_i,
  input  logic [3:0][36:0]             lq_i,
  output fgd_pkg::side_t               side_o,
  output logic [fgd_pkg::DQW-1:0]      dq_o,
  output logic [3:0]                   neg_o,
  output logic [3:0][fgd_pkg::DQW-1:0] rem_o,
  output logic [3:0][36:0]             lq_o
);
  import fgd_pkg::*;

  logic [3:0][DQW:0]   cand;
  logic [3:0]          take;
  logic [3:0][DQW-1:0] rem_d;
  logic [3:0][36:0]    lq_d;
  side_t               side_q;
  logic [DQW-1:0]      dq_q;
  logic [3:0]          neg_q;
  logic [3:0][DQW-1:0] rem_q;
  logic [3:0][36:0]    lq_q;

  // Dividend bits shift out of the top of lq while quotient bits shift in below.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cand[l] = {rem_i[l], lq_i[l][36]};
      take[l] = (cand[l] >= {1'b0, dq_i});
      rem_d[l] = take[l] ? DQW'(cand[l] - {1'b0, dq_i}) : cand[l][DQW-1:0];
      lq_d[l] = {lq_i[l][35:0], take[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q <= dq_i;
      neg_q <= neg_i;
      rem_q <= rem_d;
      lq_q <= lq_d;
    end
  end

  assign side_o = side_q;
  assign dq_o = dq_q;
  assign neg_o = neg_q;
  assign rem_o = rem_q;
  assign lq_o = lq_q;

endmodule

// ----- rtl/core/fk_ghost_division_operator_core.sv -----
// A request passes the 31 square-root cells, the CORDIC cells and the 37 divider cells
// between registered stages on its way to the result.
// Throughput: one request per cycle; the whole pipeline holds only while the
// output register is full and stalled. Reset clears all valid bits and loads
// the register defaults; no clearing pass is needed.
module fk_ghost_division_operator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] spec_re_i,
  input  logic signed [31:0] spec_im_i,
  input  logic signed [31:0] ang_freq_i,
  input  logic signed [31:0] wavenum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] up_re_o,
  output logic signed [31:0] up_im_o,
  output logic signed [31:0] down_re_o,
  output logic signed [31:0] down_im_o,
  output logic        evanescent_o,
  output logic        zero_divisor_o
);
  import fgd_pkg::*;

  logic adv;

  // Configuration registers.
  logic [31:0] slowness_q;
  logic [31:0] depth_q;
  logic [31:0] stab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slowness_q <= SLOWNESS_RST;
      depth_q <= DEPTH_RST;
      stab_q <= STAB_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOWNESS: slowness_q <= cfg_data_i;
        CFG_DEPTH: depth_q <= cfg_data_i;
        CFG_STAB: stab_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: vertical slowness term a and scaled wavenumber k.
  side_t       s1_side_d, s1_side_q;
  logic [31:0] om_abs, kx_abs;
  logic [63:0] a_prod;
  logic [30:0] s1_a_q;
  logic [23:0] s1_k_q;

  assign om_abs = ang_freq_i[31] ? 32'(-ang_freq_i) : ang_freq_i;
  assign kx_abs = wavenum_i[31] ? 32'(-wavenum_i) : wavenum_i;
  assign a_prod = 64'(om_abs) * 64'(slowness_q);

  always_comb begin
    s1_side_d = '0;
    s1_side_d.vld = in_valid_i;
    s1_side_d.zr = spec_re_i;
    s1_side_d.zi = spec_im_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
    end else if (adv) begin
      s1_side_q <= s1_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q <= a_prod[62:32];
      s1_k_q <= kx_abs[31:8];
    end
  end

  // Stage 2: squares.
  side_t       s2_side_q;
  logic [61:0] s2_a2_q;
  logic [47:0] s2_k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_side_q <= '0;
    end else if (adv) begin
      s2_side_q <= s1_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a2_q <= 62'(s1_a_q) * 62'(s1_a_q);
      s2_k2_q <= 48'(s1_k_q) * 48'(s1_k_q);
    end
  end

  // Stage 3: radicand and evanescence test.
  side_t       s3_side_d, s3_side_q;
  logic        evan;
  logic [61:0] s3_r_q;

  assign evan = (s2_a2_q < 62'(s2_k2_q));

  always_comb begin
    s3_side_d = s2_side_q;
    s3_side_d.evan = evan;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_side_q <= '0;
    end else if (adv) begin
      s3_side_q <= s3_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_r_q <= evan ? '0 : (s2_a2_q - 62'(s2_k2_q));
    end
  end

  // Square-root chain: kz = floor(sqrt(r)).
  side_t       sq_side [SQRT_N+1];
  logic [61:0] sq_op [SQRT_N+1];
  logic [31:0] sq_rem [SQRT_N+1];
  logic [30:0] sq_root [SQRT_N+1];

  assign sq_side[0] = s3_side_q;
  assign sq_op[0] = s3_r_q;
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    fgd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .side_i (sq_side[i]),
      .op_i   (sq_op[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_o (sq_side[i+1]),
      .op_o   (sq_op[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // Stage 4: half the phase product, depth * kz.
  side_t       s4_side_q;
  logic [62:0] s4_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
    end else if (adv) begin
      s4_side_q <= sq_side[SQRT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ph_q <= 63'(depth_q) * 63'(sq_root[SQRT_N]);
    end
  end

  // Stage 5: partial products of the phase with 1/(2*pi).
  side_t       s5_side_q;
  logic [63:0] ph;
  logic [63:0] s5_p00_q, s5_p01_q, s5_p10_q, s5_p11_q;

  assign ph = {s4_ph_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_side_q <= '0;
    end else if (adv) begin
      s5_side_q <= s4_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_p00_q <= 64'(ph[31:0]) * 64'(INV_TWO_PI[31:0]);
      s5_p01_q <= 64'(ph[31:0]) * 64'(INV_TWO_PI[63:32]);
      s5_p10_q <= 64'(ph[63:32]) * 64'(INV_TWO_PI[31:0]);
      s5_p11_q <= 64'(ph[63:32]) * 64'(INV_TWO_PI[63:32]);
    end
  end

  // Stage 6: phase in turns, bits 64 to 95 of the full product.
  side_t       s6_side_q;
  logic [33:0] mid;
  logic [31:0] turns;
  logic [31:0] s6_turns_q;

  assign mid = 34'(s5_p00_q[63:32]) + 34'(s5_p01_q[31:0]) + 34'(s5_p10_q[31:0]);
  assign turns = s5_p11_q[31:0] + s5_p01_q[63:32] + s5_p10_q[63:32] + 32'(mid[33:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_side_q <= '0;
    end else if (adv) begin
      s6_side_q <= s5_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_turns_q <= turns;
    end
  end

  // Stage 7: fold the angle into the right half plane.
  side_t                s7_side_d, s7_side_q;
  logic signed [CW-1:0] z_ext, z_fold;
  logic signed [CW-1:0] s7_z_q;

  assign z_ext = CW'($signed(s6_turns_q));

  always_comb begin
    s7_side_d = s6_side_q;
    z_fold = z_ext;
    s7_side_d.flip = 1'b0;
    if (z_ext > QUARTER_TURN) begin
      z_fold = z_ext - HALF_TURN;
      s7_side_d.flip = 1'b1;
    end else if (z_ext < -QUARTER_TURN) begin
      z_fold = z_ext + HALF_TURN;
      s7_side_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_side_q <= '0;
    end else if (adv) begin
      s7_side_q <= s7_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_z_q <= z_fold;
    end
  end

  // CORDIC chain: cos and sin in Q2.30.
  side_t                cc_side [CORDIC_N+1];
  logic signed [CW-1:0] cc_x [CORDIC_N+1];
  logic signed [CW-1:0] cc_y [CORDIC_N+1];
  logic signed [CW-1:0] cc_z [CORDIC_N+1];

  assign cc_side[0] = s7_side_q;
  assign cc_x[0] = CORDIC_GAIN;
  assign cc_y[0] = '0;
  assign cc_z[0] = s7_z_q;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    fgd_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .idx_i  (5'(i)),
      .side_i (cc_side[i]),
      .x_i    (cc_x[i]),
      .y_i    (cc_y[i]),
      .z_i    (cc_z[i]),
      .side_o (cc_side[i+1]),
      .x_o    (cc_x[i+1]),
      .y_o    (cc_y[i+1]),
      .z_o    (cc_z[i+1])
    );
  end

  // Stage 8: divisor real and imaginary parts.
  side_t                s8_side_q;
  logic signed [CW-1:0] cos_v, sin_v;
  logic signed [41:0]   s8_dr_q;
  logic signed [CW-1:0] s8_di_q;

  assign cos_v = cc_side[CORDIC_N].flip ? -cc_x[CORDIC_N] : cc_x[CORDIC_N];
  assign sin_v = cc_side[CORDIC_N].flip ? -cc_y[CORDIC_N] : cc_y[CORDIC_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_side_q <= '0;
    end else if (adv) begin
      s8_side_q <= cc_side[CORDIC_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_dr_q <= 42'sh40000000 - 42'(cos_v) + $signed({4'b0000, stab_q, 6'b000000});
      s8_di_q <= sin_v;
    end
  end

  // Stage 9: larger magnitude of the divisor parts and the zero test.
  side_t                s9_side_d, s9_side_q;
  logic [41:0]          dr_abs;
  logic [CW-1:0]        di_abs;
  logic [40:0]          m_v;
  logic [40:0]          s9_m_q;
  logic signed [41:0]   s9_dr_q;
  logic signed [CW-1:0] s9_di_q;

  assign dr_abs = s8_dr_q[41] ? 42'(-s8_dr_q) : s8_dr_q;
  assign di_abs = s8_di_q[CW-1] ? CW'(-s8_di_q) : s8_di_q;
  assign m_v = (dr_abs[40:0] > 41'(di_abs)) ? dr_abs[40:0] : 41'(di_abs);

  always_comb begin
    s9_side_d = s8_side_q;
    s9_side_d.zdiv = (m_v == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_side_q <= '0;
    end else if (adv) begin
      s9_side_q <= s9_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_m_q <= m_v;
      s9_dr_q <= s8_dr_q;
      s9_di_q <= s8_di_q;
    end
  end

  // Stage 10: normalizing shift from the leading one of the magnitude.
  side_t                s10_side_d, s10_side_q;
  logic [5:0]           lead;
  logic signed [41:0]   s10_dr_q;
  logic signed [CW-1:0] s10_di_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < 41; b++) begin
      if (s9_m_q[b]) begin
        lead = 6'(b);
      end
    end
    s10_side_d = s9_side_q;
    s10_side_d.sh = lead - 6'd29;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_side_q <= '0;
    end else if (adv) begin
      s10_side_q <= s10_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_dr_q <= s9_dr_q;
      s10_di_q <= s9_di_q;
    end
  end

  // Stage 11: scale the divisor by the power of two.
  side_t              s11_side_q;
  logic [4:0]         nrm_amt;
  logic signed [41:0] di_wide, dr_scl, di_scl;
  logic signed [31:0] s11_dr_q, s11_di_q;

  assign nrm_amt = s10_side_q.sh[5] ? 5'(-s10_side_q.sh) : s10_side_q.sh[4:0];
  assign di_wide = 42'(s10_di_q);
  assign dr_scl = s10_side_q.sh[5] ? (s10_dr_q <<< nrm_amt) : (s10_dr_q >>> nrm_amt);
  assign di_scl = s10_side_q.sh[5] ? (di_wide <<< nrm_amt) : (di_wide >>> nrm_amt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s11_side_q <= '0;
    end else if (adv) begin
      s11_side_q <= s10_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s11_dr_q <= 32'(dr_scl);
      s11_di_q <= 32'(di_scl);
    end
  end

  // Stage 12: squares of the divisor and the cross products with the sample.
  side_t              s12_side_q;
  logic signed [63:0] s12_rr_q, s12_ii_q;
  logic signed [63:0] s12_pa_q, s12_pb_q, s12_pc_q, s12_pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_side_q <= '0;
    end else if (adv) begin
      s12_side_q <= s11_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s12_rr_q <= 64'(s11_dr_q) * 64'(s11_dr_q);
      s12_ii_q <= 64'(s11_di_q) * 64'(s11_di_q);
      s12_pa_q <= 64'(s11_side_q.zr) * 64'(s11_dr_q);
      s12_pb_q <= 64'(s11_side_q.zi) * 64'(s11_di_q);
      s12_pc_q <= 64'(s11_side_q.zi) * 64'(s11_dr_q);
      s12_pd_q <= 64'(s11_side_q.zr) * 64'(s11_di_q);
    end
  end

  // Stage 13: numerators of the four outputs and the scaled divisor norm.
  side_t              s13_side_q;
  logic [63:0]        den;
  logic [DQW-1:0]     dq_v;
  logic signed [64:0] s13_num_q [4];
  logic [DQW-1:0]     s13_dq_q;

  assign den = 64'(s12_rr_q) + 64'(s12_ii_q);

  always_comb begin
    dq_v = den[61:30];
    if (s12_side_q.zdiv) begin
      dq_v = DQW'(32'h40000000);
    end else if (dq_v == '0) begin
      dq_v = DQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s13_side_q <= '0;
    end else if (adv) begin
      s13_side_q <= s12_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s13_num_q[0] <= 65'(s12_pa_q) + 65'(s12_pb_q);
      s13_num_q[1] <= 65'(s12_pc_q) - 65'(s12_pd_q);
      s13_num_q[2] <= 65'(s12_pa_q) - 65'(s12_pb_q);
      s13_num_q[3] <= 65'(s12_pc_q) + 65'(s12_pd_q);
      s13_dq_q <= dq_v;
    end
  end

  // Stage 14: sign and magnitude of each numerator, loaded into the divider.
  side_t               s14_side_q;
  logic [3:0]          neg_v;
  logic [3:0][64:0]    mag_v;
  logic [3:0][DQW-1:0] rem0_v;
  logic [3:0][36:0]    lq0_v;
  logic [DQW-1:0]      s14_dq_q;
  logic [3:0]          s14_neg_q;
  logic [3:0][DQW-1:0] s14_rem_q;
  logic [3:0][36:0]    s14_lq_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      neg_v[l] = s13_num_q[l][64];
      mag_v[l] = neg_v[l] ? 65'(-s13_num_q[l]) : s13_num_q[l];
      rem0_v[l] = DQW'(mag_v[l][64:37]);
      lq0_v[l] = mag_v[l][36:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s14_side_q <= '0;
    end else if (adv) begin
      s14_side_q <= s13_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s14_dq_q <= s13_dq_q;
      s14_neg_q <= neg_v;
      s14_rem_q <= rem0_v;
      s14_lq_q <= lq0_v;
    end
  end

  // Divider chain: truncated quotients of the four numerators.
  side_t               dv_side [DIV_N+1];
  logic [DQW-1:0]      dv_dq [DIV_N+1];
  logic [3:0]          dv_neg [DIV_N+1];
  logic [3:0][DQW-1:0] dv_rem [DIV_N+1];
  logic [3:0][36:0]    dv_lq [DIV_N+1];

  assign dv_side[0] = s14_side_q;
  assign dv_dq[0] = s14_dq_q;
  assign dv_neg[0] = s14_neg_q;
  assign dv_rem[0] = s14_rem_q;
  assign dv_lq[0] = s14_lq_q;

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    fgd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .side_i (dv_side[i]),
      .dq_i   (dv_dq[i]),
      .neg_i  (dv_neg[i]),
      .rem_i  (dv_rem[i]),
      .lq_i   (dv_lq[i]),
      .side_o (dv_side[i+1]),
      .dq_o   (dv_dq[i+1]),
      .neg_o  (dv_neg[i+1]),
      .rem_o  (dv_rem[i+1]),
      .lq_o   (dv_lq[i+1])
    );
  end

  // Output stage: undo the normalization, saturate and apply the special cases.
  side_t              fin_side;
  logic [4:0]         fin_amt;
  logic [63:0]        lim, wide, sc;
  logic [3:0][31:0]   res_v;
  logic [31:0]        sat_re, sat_im;
  logic               out_valid_q;
  logic               evan_q, zdiv_q;
  logic [31:0]        up_re_q, up_im_q, down_re_q, down_im_q;

  assign fin_side = dv_side[DIV_N];
  assign fin_amt = fin_side.sh[5] ? 5'(-fin_side.sh) : fin_side.sh[4:0];
  assign sat_re = fin_side.zr[31] ? 32'h80000000 :
                  ((fin_side.zr != '0) ? 32'h7FFFFFFF : 32'h00000000);
  assign sat_im = fin_side.zi[31] ? 32'h80000000 :
                  ((fin_side.zi != '0) ? 32'h7FFFFFFF : 32'h00000000);

  always_comb begin
    lim = '0;
    wide = '0;
    sc = '0;
    for (int l = 0; l < 4; l++) begin
      lim = dv_neg[DIV_N][l] ? 64'h80000000 : 64'h7FFFFFFF;
      wide = 64'(dv_lq[DIV_N][l]);
      if (!fin_side.sh[5]) begin
        sc = wide >> fin_amt;
      end else if (wide > (lim >> fin_amt)) begin
        sc = lim;
      end else begin
        sc = wide << fin_amt;
      end
      if (sc > lim) begin
        sc = lim;
      end
      res_v[l] = dv_neg[DIV_N][l] ? 32'(-sc) : sc[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      evan_q <= fin_side.evan;
      zdiv_q <= fin_side.zdiv && !fin_side.evan;
      if (fin_side.evan) begin
        up_re_q <= '0;
        up_im_q <= '0;
        down_re_q <= '0;
        down_im_q <= '0;
      end else if (fin_side.zdiv) begin
        up_re_q <= sat_re;
        up_im_q <= sat_im;
        down_re_q <= sat_re;
        down_im_q <= sat_im;
      end else begin
        up_re_q <= res_v[0];
        up_im_q <= res_v[1];
        down_re_q <= res_v[2];
        down_im_q <= res_v[3];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign up_re_o = up_re_q;
  assign up_im_o = up_im_q;
  assign down_re_o = down_re_q;
  assign down_im_o = down_im_q;
  assign evanescent_o = evan_q;
  assign zero_divisor_o = zdiv_q;

`ifndef NO_ASSERTIONS
  // An evanescent result carries all-zero fields.
  a_evan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evanescent_o |->
      up_re_o == '0 && up_im_o == '0 && down_re_o == '0 && down_im_o == '0)
    else $error("evanescent result with nonzero fields");

  // The two flags never appear together.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(evanescent_o && zero_divisor_o))
    else $error("both flags raised");

  // A zero divisor saturates both fields the same way.
  a_zdiv_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> up_re_o == down_re_o && up_im_o == down_im_o)
    else $error("zero divisor outputs differ");
`endif

endmodule

// ----- tb/fgd_checker.sv -----
// Scoreboard for the f-k deghosting operator: watches the request, result and register channels.
// Depends on fgd_pkg for the register indexes, the CORDIC length and the arctangent table.
`timescale 1ns / 100ps

module fgd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] spec_re_i,
  input  logic signed [31:0] spec_im_i,
  input  logic signed [31:0] ang_freq_i,
  input  logic signed [31:0] wavenum_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] up_re_i,
  input  logic signed [31:0] up_im_i,
  input  logic signed [31:0] down_re_i,
  input  logic signed [31:0] down_im_i,
  input  logic               evanescent_i,
  input  logic               zero_divisor_i,
  output int                 errors_o,
  output int                 pending_o
);
  import fgd_pkg::*;

  typedef struct packed {
    logic signed [31:0] up_re;
    logic signed [31:0] up_im;
    logic signed [31:0] down_re;
    logic signed [31:0] down_im;
    logic               evan;
    logic               zdiv;
  } field_t;

  logic [31:0] slowness_q, depth_q, stab_q;
  field_t      fields_q[$];

  // Truncating quotient, power-of-two rescale and saturation of one output.
  function automatic logic [31:0] scaled_quotient(input longint num, input longint dq,
                                                  input int sh);
    longint q;
    longint unsigned mag, lim;
    bit neg;
    q = num / dq;
    neg = q < 0;
    mag = neg ? longint'(-q) : q;
    lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
    if (sh > 0) begin
      mag = mag >> sh;
    end else if (sh < 0) begin
      if (-sh >= 32) mag = (mag != 0) ? lim : 0;
      else if (mag > (lim >> -sh)) mag = lim;
      else mag = mag << -sh;
    end
    if (mag > lim) mag = lim;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic logic [31:0] sign_rail(input logic signed [31:0] v);
    return (v > 0) ? 32'h7FFFFFFF : ((v < 0) ? 32'h80000000 : 32'h0);
  endfunction

  // Computes the upward and downward fields of one f-k sample.
  function automatic field_t deghost(input logic signed [31:0] zr_in, zi_in, om, kx,
                                     input logic [31:0] slow, depth, stab);
    longint unsigned a, k, op, rt, one, p;
    logic [127:0] prod;
    logic [31:0] turns;
    longint v, z, x, y, t, c, s, dr, di, m, den, dq, zr, zi;
    bit flip;
    int sh;
    field_t r;
    r = '0;
    zr = zr_in;
    zi = zi_in;
    v = om;
    a = ((v < 0) ? -v : v) * 64'(slow);
    a = a >> 32;
    v = kx;
    k = ((v < 0) ? -v : v) >> 8;
    if (a * a < k * k) begin
      r.evan = 1'b1;
      return r;
    end
    // Bitwise integer square root of the radicand.
    op = a * a - k * k;
    rt = 0;
    one = 64'd1 << 62;
    while (one > op) one = one >> 2;
    while (one != 0) begin
      if (op >= rt + one) begin
        op = op - (rt + one);
        rt = (rt >> 1) + one;
      end else begin
        rt = rt >> 1;
      end
      one = one >> 2;
    end
    p = 2 * (64'(depth) * rt);
    prod = {64'd0, p} * {64'd0, INV_TWO_PI};
    turns = prod[95:64];
    // Half-turn fold, then CORDIC rotations with floor shifts.
    z = longint'($signed(turns));
    flip = 0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      flip = 1;
    end
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z = z - longint'(atan_turns(5'(i)));
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z = z + longint'(atan_turns(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    dr = (64'sd1 << 30) - c + longint'(stab) * 64;
    di = s;
    m = ((dr < 0) ? -dr : dr);
    if (((di < 0) ? -di : di) > m) m = (di < 0) ? -di : di;
    if (m == 0) begin
      r.up_re = sign_rail(zr_in);
      r.up_im = sign_rail(zi_in);
      r.down_re = sign_rail(zr_in);
      r.down_im = sign_rail(zi_in);
      r.zdiv = 1'b1;
      return r;
    end
    // Normalize the divisor into [2^29, 2^30).
    sh = 0;
    while (m >= (64'sd1 << 30)) begin
      m = m >>> 1;
      sh++;
    end
    while (m < (64'sd1 << 29)) begin
      m = m <<< 1;
      sh--;
    end
    if (sh >= 0) begin
      dr = dr >>> sh;
      di = di >>> sh;
    end else begin
      dr = dr * (64'sd1 << -sh);
      di = di * (64'sd1 << -sh);
    end
    den = dr * dr + di * di;
    dq = den >>> 30;
    if (dq == 0) dq = 1;
    r.up_re = scaled_quotient(zr * dr + zi * di, dq, sh);
    r.up_im = scaled_quotient(zi * dr - zr * di, dq, sh);
    r.down_re = scaled_quotient(zr * dr - zi * di, dq, sh);
    r.down_im = scaled_quotient(zi * dr + zr * di, dq, sh);
    return r;
  endfunction

  assign pending_o = fields_q.size();

  // Track register writes, predict each accepted request and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    field_t got, want;
    if (!rst_ni) begin
      slowness_q <= SLOWNESS_RST;
      depth_q <= DEPTH_RST;
      stab_q <= STAB_RST;
      fields_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SLOWNESS: slowness_q <= cfg_data_i;
          CFG_DEPTH: depth_q <= cfg_data_i;
          CFG_STAB: stab_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{up_re_i, up_im_i, down_re_i, down_im_i, evanescent_i, zero_divisor_i};
        if (fields_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %h", got);
          errors_o <= errors_o + 1;
        end else begin
          want = fields_q.pop_front();
          if (got.up_re !== want.up_re || got.up_im !== want.up_im ||
              got.down_re !== want.down_re || got.down_im !== want.down_im ||
              got.evan !== want.evan || got.zdiv !== want.zdiv) begin
            if (errors_o < 10) begin
              $display("mismatch: up exp %h %h got %h %h", want.up_re, want.up_im,
                       got.up_re, got.up_im);
              $display("  down exp %h %h got %h %h, flags exp %b%b got %b%b",
                       want.down_re, want.down_im, got.down_re, got.down_im,
                       want.evan, want.zdiv, got.evan, got.zdiv);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fields_q.push_back(deghost(spec_re_i, spec_im_i, ang_freq_i, wavenum_i,
                                   slowness_q, depth_q, stab_q));
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Stimulus and verdict for the f-k deghosting operator core.
// Depends on fgd_pkg, fk_ghost_division_operator_core and fgd_checker.
`timescale 1ns / 100ps

module tb_top;
  import fgd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SLOWNESS;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] spec_re = '0, spec_im = '0, ang_freq = '0, wavenum = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] up_re, up_im, down_re, down_im;
  logic evanescent, zero_divisor;
  int errors, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] slowness_now = SLOWNESS_RST;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fk_ghost_division_operator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .spec_re_i(spec_re), .spec_im_i(spec_im), .ang_freq_i(ang_freq), .wavenum_i(wavenum),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .up_re_o(up_re), .up_im_o(up_im), .down_re_o(down_re), .down_im_o(down_im),
    .evanescent_o(evanescent), .zero_divisor_o(zero_divisor)
  );

  fgd_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .spec_re_i(spec_re), .spec_im_i(spec_im), .ang_freq_i(ang_freq), .wavenum_i(wavenum),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .up_re_i(up_re), .up_im_i(up_im), .down_re_i(down_re), .down_im_i(down_im),
    .evanescent_i(evanescent), .zero_divisor_i(zero_divisor),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // One register write, only issued while the pipeline is empty.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SLOWNESS) slowness_now = val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One request; valid stays high across back-to-back requests.
  task automatic send_sample(input logic [31:0] re, im, om, kx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    spec_re <= re;
    spec_im <= im;
    ang_freq <= om;
    wavenum <= kx;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Mostly propagating samples with kx inside the cone, the rest unconstrained.
  task automatic send_random;
    logic [31:0] re, im, om, kx;
    longint unsigned a;
    longint mag;
    om = $urandom();
    if ($urandom_range(3) == 0) om = $signed(om) >>> $urandom_range(31);
    mag = $signed(om);
    a = (((mag < 0) ? -mag : mag) * 64'(slowness_now)) >> 32;
    a = a << 8;
    if (a > 64'h7FFFFFFF) a = 64'h7FFFFFFF;
    if ($urandom_range(9) < 7) begin
      kx = 32'(longint'($urandom_range(32'(a))));
      if ($urandom_range(1)) kx = -kx;
    end else begin
      kx = $urandom();
    end
    re = $urandom();
    im = $urandom();
    if ($urandom_range(3) == 0) begin
      re = $signed(re) >>> $urandom_range(31);
      im = $signed(im) >>> $urandom_range(31);
    end
    send_sample(re, im, om, kx);
  endtask

  // Drop valid at once so the last request is not offered again.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("** fk_ghost_division_operator_core: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0] slow_set[6], depth_set[6], stab_set[6];
    slow_set = '{SLOWNESS_RST, 32'hFFFFFFFF, 32'h0, 32'h00100000, 32'h00000000, 32'hFFFFFFFF};
    depth_set = '{DEPTH_RST, 32'hFFFFFFFF, 32'h0, 32'h00010000, 32'h00FF0000, 32'h0};
    stab_set = '{STAB_RST, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h00001000, 32'h0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset registers.
    send_sample(0, 0, 0, 0);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_sample(32'h01000000, 32'hFF000000, 0, 32'h80000000);
    send_sample(32'h01000000, 0, 32'h00640000, 32'h00010000);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h00000100);
    drain();
    // Half slowness makes a and k equal for some of these samples: a radicand of exactly zero.
    write_reg(CFG_SLOWNESS, 32'h80000000);
    write_reg(CFG_STAB, 32'h0);
    write_reg(2'd3, 32'hFFFFFFFF);
    send_sample(32'h00400000, 32'hFFC00000, 32'h00000200, 32'h00010000);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFE, 32'h3FFFFFFF);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h40000000);
    send_sample(32'h12345678, 32'h9ABCDEF0, 32'h00000002, 32'h00000100);
    send_sample(0, 32'h00000001, 0, 32'h000000FF);
    send_sample(32'hFFFFFFFF, 0, 32'h00000001, 32'h00000200);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 17;
        recv_stall_pct = 55;
      end else if (ph < 4) begin
        send_idle_pct = 55;
        recv_stall_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(CFG_SLOWNESS, (ph == 3) ? $urandom() : slow_set[ph]);
      write_reg(CFG_DEPTH, (ph == 5) ? $urandom() : depth_set[ph]);
      write_reg(CFG_STAB, stab_set[ph]);
      repeat (173) send_random();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("** fk_ghost_division_operator_core: PASSED **");
    end else begin
      $display("** fk_ghost_division_operator_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fgd_pkg.sv
rtl/core/fgd_sqrt_cell.sv
rtl/core/fgd_cordic_cell.sv
rtl/core/fgd_div_cell.sv
rtl/core/fk_ghost_division_operator_core.sv
tb/fgd_checker.sv
tb/tb_top.sv
